// File: rtl/core/dvs_pkg.sv
// shared types and constants for the distinct value set engine
// no dependencies; imported by every module of the block
package dvs_pkg;

    localparam int DATA_W       = 32;
    localparam int POS_W        = 10;
    localparam int MODE_W       = 3;
    localparam int CAPACITY_DEF = 1024;

    // transaction codes
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PROBE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_COMMIT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_SHIFT,
        ST_READ,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic was_present;
        logic dropped;
        logic bad_position;
    } flags_t;

endpackage

// File: rtl/core/distinct_value_set_engine_core.sv
// top level of the distinct value set engine: two bank memories, sequencer, output register
// depends on dvs_pkg, dvs_ram and dvs_ctrl
//
// Keeps an insertion-ordered set of distinct 32-bit values plus a staging set used to
// build an intersection. Each input transaction returns exactly one result transaction.
// One transaction is in work at a time; in_ready is low from acceptance until the result
// has moved into the output register, which then waits for out_ready while the next
// transaction is taken. Insert, remove and intersect probe are bound by the single read
// port of each bank memory, which the shared compare unit walks one entry per cycle; the
// remove walk then streams every later entry down one place through the same port.
// Commit costs nothing extra because the main and staging roles swap between the two
// banks. Neither store needs clearing after reset: only entries below the live counts
// are ever read.
module distinct_value_set_engine_core
    import dvs_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int IDX_W    = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // input transaction
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [MODE_W-1:0]        mode,
    input  logic signed [DATA_W-1:0] value,
    input  logic [POS_W-1:0]         position,
    // result transaction
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     was_present,
    output logic [CNT_W-1:0]         element_count,
    output logic                     dropped,
    output logic signed [DATA_W-1:0] read_value,
    output logic                     bad_position
);

    logic              res_valid;
    logic              res_taken;
    flags_t            res_flags;
    logic [CNT_W-1:0]  res_count;
    logic [DATA_W-1:0] res_read_value;

    logic              bank;
    logic [IDX_W-1:0]  rd_addr;
    logic              main_re, stg_re;
    logic [DATA_W-1:0] main_rdata, stg_rdata;
    logic              main_we, stg_we;
    logic [IDX_W-1:0]  main_wa, stg_wa;
    logic [DATA_W-1:0] main_wd, stg_wd;

    // physical bank ports
    logic              ram0_we, ram1_we, ram0_re, ram1_re;
    logic [IDX_W-1:0]  ram0_wa, ram1_wa;
    logic [DATA_W-1:0] ram0_wd, ram1_wd, ram0_rd, ram1_rd;

    // output register
    logic              out_valid_reg, out_valid_next;
    flags_t            out_flags_reg;
    logic [CNT_W-1:0]  out_count_reg;
    logic [DATA_W-1:0] out_read_reg;

    dvs_ctrl #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .value          ($unsigned(value)),
        .position       (position),
        .res_valid      (res_valid),
        .res_taken      (res_taken),
        .res_flags      (res_flags),
        .res_count      (res_count),
        .res_read_value (res_read_value),
        .bank           (bank),
        .rd_addr        (rd_addr),
        .main_re        (main_re),
        .stg_re         (stg_re),
        .main_rdata     (main_rdata),
        .stg_rdata      (stg_rdata),
        .main_we        (main_we),
        .main_wa        (main_wa),
        .main_wd        (main_wd),
        .stg_we         (stg_we),
        .stg_wa         (stg_wa),
        .stg_wd         (stg_wd)
    );

    // bank 0 holds the main set while bank is low, bank 1 while it is high
    assign ram0_we    = bank ? stg_we : main_we;
    assign ram0_wa    = bank ? stg_wa : main_wa;
    assign ram0_wd    = bank ? stg_wd : main_wd;
    assign ram0_re    = bank ? stg_re : main_re;
    assign ram1_we    = bank ? main_we : stg_we;
    assign ram1_wa    = bank ? main_wa : stg_wa;
    assign ram1_wd    = bank ? main_wd : stg_wd;
    assign ram1_re    = bank ? main_re : stg_re;
    assign main_rdata = bank ? ram1_rd : ram0_rd;
    assign stg_rdata  = bank ? ram0_rd : ram1_rd;

    dvs_ram #(
        .DEPTH  (CAPACITY),
        .ADDR_W (IDX_W)
    ) u_bank0 (
        .clk (clk),
        .we  (ram0_we),
        .wa  (ram0_wa),
        .wd  (ram0_wd),
        .re  (ram0_re),
        .ra  (rd_addr),
        .rd  (ram0_rd)
    );

    dvs_ram #(
        .DEPTH  (CAPACITY),
        .ADDR_W (IDX_W)
    ) u_bank1 (
        .clk (clk),
        .we  (ram1_we),
        .wa  (ram1_wa),
        .wd  (ram1_wd),
        .re  (ram1_re),
        .ra  (rd_addr),
        .rd  (ram1_rd)
    );

    // result moves on when the output slot is empty or being emptied this cycle
    assign res_taken = res_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_taken)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_taken)
        begin
            out_flags_reg <= res_flags;
            out_count_reg <= res_count;
            out_read_reg  <= res_read_value;
        end
    end

    assign out_valid     = out_valid_reg;
    assign was_present   = out_flags_reg.was_present;
    assign element_count = out_count_reg;
    assign dropped       = out_flags_reg.dropped;
    assign read_value    = $signed(out_read_reg);
    assign bad_position  = out_flags_reg.bad_position;

    // main set size never passes the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_count <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    // one transaction at a time: acceptance closes the input side
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while a transaction is in work");

    // an out-of-range read returns zero
    a_bad_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_position) |-> (read_value == '0))
        else $error("bad position with non-zero read value");

    // a refused append and a bad read cannot come from the same transaction
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(dropped && bad_position))
        else $error("dropped and bad position both set");

endmodule

// File: rtl/core/dvs_ram.sv
// simple dual-port store: one write port, one registered read port
// depends on dvs_pkg for the data width
module dvs_ram
    import dvs_pkg::*;
#(
    parameter int DEPTH  = CAPACITY_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] wa,
    input  logic [DATA_W-1:0] wd,
    input  logic              re,
    input  logic [ADDR_W-1:0] ra,
    output logic [DATA_W-1:0] rd
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_reg <= mem[ra];
        end
    end

    assign rd = rd_reg;

endmodule

// File: rtl/core/dvs_ctrl.sv
// sequencer and shared compare unit: walks the stores one entry per cycle
// depends on dvs_pkg; drives the two bank memories held in the top level
module dvs_ctrl
    import dvs_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int IDX_W    = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [MODE_W-1:0] mode,
    input  logic [DATA_W-1:0] value,
    input  logic [POS_W-1:0]  position,
    output logic              res_valid,
    input  logic              res_taken,
    output flags_t            res_flags,
    output logic [CNT_W-1:0]  res_count,
    output logic [DATA_W-1:0] res_read_value,
    output logic              bank,
    output logic [IDX_W-1:0]  rd_addr,
    output logic              main_re,
    output logic              stg_re,
    input  logic [DATA_W-1:0] main_rdata,
    input  logic [DATA_W-1:0] stg_rdata,
    output logic              main_we,
    output logic [IDX_W-1:0]  main_wa,
    output logic [DATA_W-1:0] main_wd,
    output logic              stg_we,
    output logic [IDX_W-1:0]  stg_wa,
    output logic [DATA_W-1:0] stg_wd
);

    localparam int CMP_W = CNT_W + POS_W;

    state_t            state_reg, state_next;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [DATA_W-1:0] value_reg, value_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [CNT_W-1:0]  staged_reg, staged_next;
    logic              bank_reg, bank_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;
    logic              stage_search_reg, stage_search_next;
    flags_t            flags_reg, flags_next;
    logic [DATA_W-1:0] read_reg, read_next;

    logic [CNT_W-1:0]  cur_len;
    logic [DATA_W-1:0] cur_rdata;
    logic              hit;
    logic              issue_more;
    logic [CNT_W-1:0]  issue_prev;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            total_reg        <= '0;
            staged_reg       <= '0;
            bank_reg         <= 1'b0;
            pend_reg         <= 1'b0;
            stage_search_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            total_reg        <= total_next;
            staged_reg       <= staged_next;
            bank_reg         <= bank_next;
            pend_reg         <= pend_next;
            stage_search_reg <= stage_search_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        value_reg    <= value_next;
        issue_reg    <= issue_next;
        pend_idx_reg <= pend_idx_next;
        flags_reg    <= flags_next;
        read_reg     <= read_next;
    end

    // the one compare unit, fed from whichever store is being walked
    assign cur_len    = stage_search_reg ? staged_reg : total_reg;
    assign cur_rdata  = stage_search_reg ? stg_rdata : main_rdata;
    assign hit        = pend_reg && (cur_rdata == value_reg);
    assign issue_more = issue_reg < cur_len;
    assign issue_prev = issue_reg - CNT_W'(1);

    always_comb
    begin
        state_next        = state_reg;
        mode_next         = mode_reg;
        value_next        = value_reg;
        total_next        = total_reg;
        staged_next       = staged_reg;
        bank_next         = bank_reg;
        issue_next        = issue_reg;
        pend_next         = pend_reg;
        pend_idx_next     = pend_idx_reg;
        stage_search_next = stage_search_reg;
        flags_next        = flags_reg;
        read_next         = read_reg;
        rd_addr           = issue_reg[IDX_W-1:0];
        main_re           = 1'b0;
        stg_re            = 1'b0;
        main_we           = 1'b0;
        main_wa           = total_reg[IDX_W-1:0];
        main_wd           = value_reg;
        stg_we            = 1'b0;
        stg_wa            = staged_reg[IDX_W-1:0];
        stg_wd            = value_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next         = mode;
                    value_next        = value;
                    flags_next        = '0;
                    read_next         = '0;
                    issue_next        = '0;
                    pend_next         = 1'b0;
                    stage_search_next = 1'b0;
                    case (mode)
                        MODE_INSERT, MODE_REMOVE, MODE_PROBE:
                        begin
                            state_next = ST_FIND;
                        end
                        MODE_COMMIT:
                        begin
                            // swap banks: staging becomes main, old main is free
                            bank_next   = ~bank_reg;
                            total_next  = staged_reg;
                            staged_next = '0;
                            state_next  = ST_RESP;
                        end
                        MODE_READ:
                        begin
                            if (CMP_W'(position) < CMP_W'(total_reg))
                            begin
                                main_re    = 1'b1;
                                rd_addr    = IDX_W'(position);
                                state_next = ST_READ;
                            end
                            else
                            begin
                                flags_next.bad_position = 1'b1;
                                state_next              = ST_RESP;
                            end
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            ST_FIND:
            begin
                if (hit)
                begin
                    if (stage_search_reg)
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        flags_next.was_present = 1'b1;
                        case (mode_reg)
                            MODE_REMOVE:
                            begin
                                issue_next = CNT_W'(pend_idx_reg) + CNT_W'(1);
                                pend_next  = 1'b0;
                                state_next = ST_SHIFT;
                            end
                            MODE_PROBE:
                            begin
                                stage_search_next = 1'b1;
                                issue_next        = '0;
                                pend_next         = 1'b0;
                            end
                            default:
                            begin
                                state_next = ST_RESP;
                            end
                        endcase
                    end
                end
                else if (!issue_more && !pend_reg)
                begin
                    // walk finished without a match
                    if (stage_search_reg)
                    begin
                        if (staged_reg < CNT_W'(CAPACITY))
                        begin
                            stg_we      = 1'b1;
                            staged_next = staged_reg + CNT_W'(1);
                        end
                        else
                        begin
                            flags_next.dropped = 1'b1;
                        end
                    end
                    else if (mode_reg == MODE_INSERT)
                    begin
                        if (total_reg < CNT_W'(CAPACITY))
                        begin
                            main_we    = 1'b1;
                            total_next = total_reg + CNT_W'(1);
                        end
                        else
                        begin
                            flags_next.dropped = 1'b1;
                        end
                    end
                    state_next = ST_RESP;
                end
                else
                begin
                    main_re       = !stage_search_reg && issue_more;
                    stg_re        = stage_search_reg && issue_more;
                    pend_next     = issue_more;
                    pend_idx_next = issue_reg[IDX_W-1:0];
                    if (issue_more)
                    begin
                        issue_next = issue_reg + CNT_W'(1);
                    end
                end
            end

            ST_SHIFT:
            begin
                // entry j is read, then written one place lower
                if (pend_reg)
                begin
                    main_we = 1'b1;
                    main_wa = pend_idx_reg;
                    main_wd = main_rdata;
                end
                if (!issue_more && !pend_reg)
                begin
                    total_next = total_reg - CNT_W'(1);
                    state_next = ST_RESP;
                end
                else
                begin
                    main_re       = issue_more;
                    pend_next     = issue_more;
                    pend_idx_next = issue_prev[IDX_W-1:0];
                    if (issue_more)
                    begin
                        issue_next = issue_reg + CNT_W'(1);
                    end
                end
            end

            ST_READ:
            begin
                read_next  = main_rdata;
                state_next = ST_RESP;
            end

            ST_RESP:
            begin
                if (res_taken)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready       = (state_reg == ST_IDLE);
    assign res_valid      = (state_reg == ST_RESP);
    assign res_flags      = flags_reg;
    assign res_count      = total_reg;
    assign res_read_value = read_reg;
    assign bank           = bank_reg;

endmodule

// File: bench/tb.sv
// self-checking testbench for distinct_value_set_engine_core
// depends on dvs_pkg and the rtl of the block; keeps its own model of both sets
// directed corners, random traffic under three stall patterns, then long walks on a bigger set
module tb;
    import dvs_pkg::*;

    localparam int CAP           = CAPACITY_DEF;
    localparam int CNT_W         = $clog2(CAP + 1);
    localparam int POOL_SIZE     = 48;
    localparam int SET_SOFT_MAX  = 40;
    localparam int FILL_TOTAL    = 60;
    localparam int LIMIT_CYCLES  = 500_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PRINT_CAP     = 50;

    // codes the block leaves unused
    localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

    localparam logic [DATA_W-1:0] VAL_MIN    = 32'h8000_0000;
    localparam logic [DATA_W-1:0] VAL_MAX    = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] VAL_NEG1   = 32'hffff_ffff;
    localparam logic [DATA_W-1:0] FILL_BASE  = 32'ha500_0000;
    localparam logic [DATA_W-1:0] VAL_OUTSET = 32'h0bad_0000;

    typedef struct packed {
        logic              was_present;
        logic [CNT_W-1:0]  element_count;
        logic              dropped;
        logic [DATA_W-1:0] read_value;
        logic              bad_position;
    } set_result_t;

    logic                     clk           = 1'b0;
    logic                     rst_n         = 1'b0;
    logic                     in_valid      = 1'b0;
    logic                     in_ready;
    logic [MODE_W-1:0]        mode          = MODE_INSERT;
    logic signed [DATA_W-1:0] value         = '0;
    logic [POS_W-1:0]         position      = '0;
    logic                     out_valid;
    logic                     out_ready     = 1'b0;
    logic                     was_present;
    logic [CNT_W-1:0]         element_count;
    logic                     dropped;
    logic signed [DATA_W-1:0] read_value;
    logic                     bad_position;

    // model of the block: main set and staging set in insertion order
    logic [DATA_W-1:0] set_members[$];
    logic [DATA_W-1:0] staged_members[$];
    set_result_t       expected_results[$];

    int send_idle_pct = 18;
    int recv_idle_pct = 57;
    int mismatch_count = 0;
    int cycle_count = 0;

    distinct_value_set_engine_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .value         (value),
        .position      (position),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .was_present   (was_present),
        .element_count (element_count),
        .dropped       (dropped),
        .read_value    (read_value),
        .bad_position  (bad_position)
    );

    always #4 clk = ~clk;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // position of v in q, or -1 when absent
    function automatic int find_member(input logic [DATA_W-1:0] q[$],
                                       input logic [DATA_W-1:0] v);
        for (int i = 0; i < q.size(); i++)
            if (q[i] == v)
                return i;
        return -1;
    endfunction

    // update the model for one accepted transaction and queue its result
    task automatic predict_set_op(input logic [MODE_W-1:0] m, input logic [DATA_W-1:0] v,
                                  input logic [POS_W-1:0] p);
        set_result_t r;
        int          at;
        r  = '0;
        at = find_member(set_members, v);
        case (m)
            MODE_INSERT:
            begin
                if (at >= 0)
                    r.was_present = 1'b1;
                else if (set_members.size() < CAP)
                    set_members.push_back(v);
                else
                    r.dropped = 1'b1;
            end
            MODE_REMOVE:
            begin
                if (at >= 0)
                begin
                    r.was_present = 1'b1;
                    set_members.delete(at);
                end
            end
            MODE_PROBE:
            begin
                if (at >= 0)
                begin
                    r.was_present = 1'b1;
                    if (find_member(staged_members, v) < 0)
                    begin
                        if (staged_members.size() < CAP)
                            staged_members.push_back(v);
                        else
                            r.dropped = 1'b1;
                    end
                end
            end
            MODE_COMMIT:
            begin
                set_members = staged_members;
                staged_members.delete();
            end
            MODE_READ:
            begin
                if (p < set_members.size())
                    r.read_value = set_members[p];
                else
                    r.bad_position = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.element_count = CNT_W'(set_members.size());
        expected_results.push_back(r);
    endtask

    // called at a rising edge; returns at the edge where the transaction is taken
    task automatic send_item(input logic [MODE_W-1:0] m, input logic [DATA_W-1:0] v,
                             input logic [POS_W-1:0] p);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        mode     <= m;
        value    <= v;
        position <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_set_op(m, v, p);
    endtask

    // empty sets, extreme values, every code and the simple corner cases
    task automatic test_directed_corners();
        send_item(MODE_READ,   '0, '0);           // read on an empty set
        send_item(MODE_REMOVE, 32'd5, '0);        // remove from an empty set
        send_item(MODE_PROBE,  32'd5, '0);
        send_item(MODE_COMMIT, '0, '0);           // commit of an empty staging set
        send_item(MODE_INSERT, VAL_MIN, '0);
        send_item(MODE_INSERT, VAL_MAX, '0);
        send_item(MODE_INSERT, '0, '0);
        send_item(MODE_INSERT, VAL_NEG1, '0);
        send_item(MODE_INSERT, '0, '0);           // already present
        send_item(MODE_READ,   '0, 10'd0);
        send_item(MODE_READ,   '0, 10'd3);
        send_item(MODE_READ,   '0, 10'd4);        // first position past the end
        send_item(MODE_READ,   VAL_NEG1, 10'd1023);
        send_item(MODE_REMOVE, VAL_MAX, '0);      // gap in the middle closes up
        send_item(MODE_REMOVE, 32'd5, '0);        // absent value
        send_item(MODE_PROBE,  VAL_NEG1, '0);
        send_item(MODE_PROBE,  VAL_NEG1, '0);     // already staged
        send_item(MODE_PROBE,  VAL_MIN, '0);
        send_item(MODE_PROBE,  32'd12345, '0);    // not in the main set
        send_item(MODE_COMMIT, VAL_NEG1, 10'h3ff);
        send_item(MODE_READ,   '0, 10'd0);
        send_item(MODE_READ,   '0, 10'd1);
        for (int c = MODE_SPARE_FIRST; c <= MODE_SPARE_LAST; c++)
            send_item(MODE_W'(c), VAL_NEG1, 10'h3ff);
    endtask

    // mostly well-formed traffic on a small value pool so that hits are common
    task automatic test_random_traffic(input int item_total);
        logic [DATA_W-1:0] value_pool[POOL_SIZE];
        logic [DATA_W-1:0] v;
        logic [POS_W-1:0]  p;
        logic [MODE_W-1:0] m;
        int                roll;
        int                ins_w;
        int                n;
        for (int i = 0; i < POOL_SIZE; i++)
            value_pool[i] = $urandom();
        value_pool[0] = VAL_MIN;
        value_pool[1] = VAL_MAX;
        for (int k = 0; k < item_total; k++)
        begin
            n     = set_members.size();
            ins_w = (n >= SET_SOFT_MAX) ? 10 : 32;
            roll  = $urandom_range(99);
            if (roll < ins_w)
                m = MODE_INSERT;
            else if (roll < ins_w + 20)
                m = MODE_REMOVE;
            else if (roll < ins_w + 40)
                m = MODE_PROBE;
            else if (roll < ins_w + 45)
                m = MODE_COMMIT;
            else if (roll < ins_w + 50)
                m = MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
            else
                m = MODE_READ;

            // value: a live member, a pool entry or something fresh
            roll = $urandom_range(99);
            if (n > 0 && (roll < 20 || (m != MODE_INSERT && roll < 75)))
                v = set_members[$urandom_range(0, n - 1)];
            else if (roll < 90)
                v = value_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                v = $urandom();

            // position mostly near the live count, sometimes anywhere
            if ($urandom_range(99) < 80)
                p = POS_W'($urandom_range(0, n + 1));
            else
                p = POS_W'($urandom_range(0, 1023));
            send_item(m, v, p);
        end
    endtask

    // build a larger main set, then walk it end to end and shift it from the front
    task automatic test_long_walks();
        logic [DATA_W-1:0] v;
        logic [DATA_W-1:0] last_v;
        last_v = FILL_BASE + DATA_W'(FILL_TOTAL - 1);
        send_item(MODE_COMMIT, '0, '0);
        send_item(MODE_COMMIT, '0, '0);           // both sets now empty
        for (int k = 0; k < FILL_TOTAL; k++)
        begin
            v = FILL_BASE + DATA_W'(k);
            send_item(MODE_INSERT, v, '0);
        end
        send_item(MODE_INSERT, last_v, '0);       // hit on the last entry
        send_item(MODE_PROBE,  last_v, '0);
        send_item(MODE_PROBE,  FILL_BASE, '0);
        send_item(MODE_PROBE,  VAL_OUTSET, '0);   // full walk without a match
        send_item(MODE_READ,   '0, POS_W'(FILL_TOTAL - 1));
        send_item(MODE_READ,   '0, POS_W'(FILL_TOTAL));
        send_item(MODE_REMOVE, FILL_BASE, '0);    // longest shift
        send_item(MODE_REMOVE, last_v, '0);       // last entry, nothing to shift
        send_item(MODE_READ,   '0, 10'd0);
        send_item(MODE_READ,   '0, POS_W'(FILL_TOTAL - 3));
        send_item(MODE_INSERT, VAL_OUTSET, '0);
        send_item(MODE_READ,   '0, POS_W'(FILL_TOTAL - 2));
        send_item(MODE_COMMIT, '0, '0);
        send_item(MODE_READ,   '0, 10'd1);
    endtask

    // result side: random back-pressure and field-by-field comparison
    always @(posedge clk)
    begin : check_results
        set_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("result transaction with nothing outstanding");
            end
            else
            begin
                want = expected_results.pop_front();
                if (was_present !== want.was_present)
                    report_mismatch($sformatf("was_present got %b want %b",
                                              was_present, want.was_present));
                if (element_count !== want.element_count)
                    report_mismatch($sformatf("element_count got %0d want %0d",
                                              element_count, want.element_count));
                if (dropped !== want.dropped)
                    report_mismatch($sformatf("dropped got %b want %b",
                                              dropped, want.dropped));
                if (read_value !== want.read_value)
                    report_mismatch($sformatf("read_value got %h want %h",
                                              read_value, want.read_value));
                if (bad_position !== want.bad_position)
                    report_mismatch($sformatf("bad_position got %b want %b",
                                              bad_position, want.bad_position));
            end
        end
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_random_traffic(160);
        send_idle_pct = 57;
        recv_idle_pct = 18;
        test_random_traffic(160);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(160);
        test_long_walks();
        in_valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: distinct_value_set_engine_core.f
rtl/core/dvs_pkg.sv
rtl/core/dvs_ram.sv
rtl/core/dvs_ctrl.sv
rtl/core/distinct_value_set_engine_core.sv
bench/tb.sv
